@@ design/jump_point_ray_scan_top_assert.svh @@
// Assertion macros for the jump point ray scan checker.
`ifndef JUMP_POINT_RAY_SCAN_TOP_ASSERT_SVH
`define JUMP_POINT_RAY_SCAN_TOP_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define JPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define JPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/jprs_pkg.sv @@
// Shared types, codes and direction tables of the jump point ray scan block.
package jprs_pkg;

    localparam int MAX_GRID  = 256;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_GOAL_X    = 2'd1;
    localparam logic [1:0] CFG_GOAL_Y    = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_READ = 5'b00100,
        ST_EVAL = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        K_CUR  = 2'd0,
        K_SIDE = 2'd1,
        K_FWD  = 2'd2
    } probe_kind_t;

    typedef struct packed {
        logic on;
        logic blk;
    } probe_t;

    function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd1, 3'd2, 3'd3: r = 2'sd1;
            3'd5, 3'd6, 3'd7: r = -2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            3'd7, 3'd0, 3'd1: r = -2'sd1;
            3'd3, 3'd4, 3'd5: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/jprs_map.sv @@
// Occupancy bitmap memory with one write port and one registered cell probe.
module jprs_map #(
    parameter int AW = 11
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [jprs_pkg::WORD_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    input  logic [jprs_pkg::BIT_W-1:0]    rd_bit,
    input  logic                          rd_on,
    output jprs_pkg::probe_t              probe
);

    logic [jprs_pkg::WORD_BITS-1:0] mem [2**AW];
    logic [jprs_pkg::WORD_BITS-1:0] data_reg;
    logic [jprs_pkg::BIT_W-1:0]     bit_reg;
    logic                           on_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
            bit_reg  <= rd_bit;
            on_reg   <= rd_on;
        end
    end

    assign probe.on  = on_reg;
    assign probe.blk = on_reg & data_reg[bit_reg];

endmodule

@@ design/jump_point_ray_scan_top.sv @@
// Top level of the jump point ray scan block: word handshakes, sequencer, registers.
//
// Input words arrive on s_tvalid/s_tready. s_tuser selects the kind: a map write
// stores one 32-bit obstacle word in the same cycle and gives no result; a scan
// walks from the start cell and gives exactly one result word on m_tvalid/m_tready.
// Configuration (grid size, goal) is written through cfg_we/cfg_index/cfg_data
// while the block is idle; the user must keep to this, the block does not enforce it.
// A scan holds s_tready low until its result is loaded. Every map probe uses the
// single read port of the bitmap memory: ST_READ registers the addressed word and
// ST_EVAL tests the cell. A straight cell probes itself and then its side tests; a
// diagonal cell also walks both of its straight sub-rays. The length of a scan is
// set by its cell walk over that one read port. After reset the grid size is
// MAX_GRID, 256, the goal is (0,0), the sequencer is idle and the map contents are
// undefined until written. When the receiver stalls, the result stays in the output
// register; the block still takes the next scan but waits in ST_DONE before loading
// its result, and map writes are taken only when idle.
module jump_point_ray_scan_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // map_row, word_index, word_data, start_x, start_y, direction
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // point_x, point_y, point_id
    output logic        m_tuser,   // found
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int LG        = $clog2(jprs_pkg::MAX_GRID);
    localparam int CW        = (LG > 8) ? LG + 2 : 10;
    localparam int WPR       = jprs_pkg::MAX_GRID / jprs_pkg::WORD_BITS;
    localparam int MAP_WORDS = jprs_pkg::MAX_GRID * WPR;
    localparam int AW        = $clog2(MAP_WORDS);

    logic [8:0] grid_size_reg;
    logic [7:0] goal_x_reg;
    logic [7:0] goal_y_reg;

    jprs_pkg::state_t      state_reg, state_next;
    jprs_pkg::probe_kind_t kind_reg, kind_next;
    logic mode_reg, mode_next;
    logic j_reg, j_next;
    logic side_reg, side_next;
    logic sub_reg, sub_next;
    logic [2:0] dir_reg, dir_next;
    logic [2:0] rdir_reg, rdir_next;
    logic signed [CW-1:0] dgx_reg, dgx_next, dgy_reg, dgy_next;
    logic signed [CW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic found_reg, found_next;
    logic [CW-1:0] resx_reg, resx_next, resy_reg, resy_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;

    logic signed [CW-1:0] grid_n;
    logic [CW+8:0]        grid_ext;
    logic signed [CW-1:0] bx, by, px, py, sdx, sdy;
    logic [2:0]           sdir;
    logic                 p_on;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic                 rd_en;
    jprs_pkg::probe_t     probe;
    logic                 goal_hit;
    logic [15:0]          point_id;

    assign grid_ext = {{CW{1'b0}}, grid_size_reg};
    assign grid_n   = (grid_ext > (CW+9)'(jprs_pkg::MAX_GRID)) ? CW'(jprs_pkg::MAX_GRID)
                                                               : CW'(grid_size_reg);

    assign bx   = mode_reg ? rx_reg : dgx_reg;
    assign by   = mode_reg ? ry_reg : dgy_reg;
    assign sdir = mode_reg ? rdir_reg : (j_reg ? dir_reg + 3'd1 : dir_reg - 3'd1);
    assign sdx  = CW'(jprs_pkg::dir_dx(sdir));
    assign sdy  = CW'(jprs_pkg::dir_dy(sdir));

    always_comb
    begin
        px = bx;
        py = by;
        case (kind_reg)
            jprs_pkg::K_SIDE:
            begin
                px = bx + (side_reg ? sdy : -sdy);
                py = by + (side_reg ? -sdx : sdx);
            end
            jprs_pkg::K_FWD:
            begin
                px = bx + (side_reg ? sdy : -sdy) + sdx;
                py = by + (side_reg ? -sdx : sdx) + sdy;
            end
            default:
            begin
                px = bx;
                py = by;
            end
        endcase
    end

    assign p_on    = (px >= 0) && (py >= 0) && (px < grid_n) && (py < grid_n);
    assign rd_addr = AW'(($unsigned(px) * WPR) + ($unsigned(py) >> jprs_pkg::BIT_W));
    assign rd_en   = (state_reg == jprs_pkg::ST_READ);
    assign wr_en   = s_tvalid && s_tready && (s_tuser == jprs_pkg::CMD_WRITE);
    assign wr_addr = AW'((s_tdata[7:0] * WPR) + s_tdata[10:8]);

    jprs_map #(
        .AW(AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[42:11]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_bit  (~py[jprs_pkg::BIT_W-1:0]),
        .rd_on   (p_on),
        .probe   (probe)
    );

    assign goal_hit = (bx == $signed(CW'(goal_x_reg))) && (by == $signed(CW'(goal_y_reg)));
    assign point_id = 16'(resx_reg) * {7'd0, grid_size_reg} + 16'(resy_reg);

    always_comb
    begin
        logic succ;
        logic fail;
        logic nxt_side;
        logic sub_fail;
        succ         = 1'b0;
        fail         = 1'b0;
        nxt_side     = 1'b0;
        sub_fail     = 1'b0;
        state_next   = state_reg;
        kind_next    = kind_reg;
        mode_next    = mode_reg;
        j_next       = j_reg;
        side_next    = side_reg;
        sub_next     = sub_reg;
        dir_next     = dir_reg;
        rdir_next    = rdir_reg;
        dgx_next     = dgx_reg;
        dgy_next     = dgy_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        found_next   = found_reg;
        resx_next    = resx_reg;
        resy_next    = resy_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            jprs_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == jprs_pkg::CMD_SCAN))
                begin
                    dir_next   = s_tdata[61:59];
                    rdir_next  = s_tdata[61:59];
                    mode_next  = ~s_tdata[59];
                    sub_next   = 1'b0;
                    dgx_next   = $signed(CW'(s_tdata[50:43]));
                    dgy_next   = $signed(CW'(s_tdata[58:51]));
                    rx_next    = $signed(CW'(s_tdata[50:43]));
                    ry_next    = $signed(CW'(s_tdata[58:51]));
                    state_next = jprs_pkg::ST_STEP;
                end
            end
            jprs_pkg::ST_STEP:
            begin
                if (mode_reg)
                begin
                    rx_next = rx_reg + CW'(jprs_pkg::dir_dx(rdir_reg));
                    ry_next = ry_reg + CW'(jprs_pkg::dir_dy(rdir_reg));
                end
                else
                begin
                    dgx_next = dgx_reg + CW'(jprs_pkg::dir_dx(dir_reg));
                    dgy_next = dgy_reg + CW'(jprs_pkg::dir_dy(dir_reg));
                end
                kind_next  = jprs_pkg::K_CUR;
                state_next = jprs_pkg::ST_READ;
            end
            jprs_pkg::ST_READ:
            begin
                state_next = jprs_pkg::ST_EVAL;
            end
            jprs_pkg::ST_EVAL:
            begin
                case (kind_reg)
                    jprs_pkg::K_CUR:
                    begin
                        if (!probe.on || probe.blk)
                        begin
                            if (mode_reg && dir_reg[0])
                            begin
                                sub_fail = 1'b1;
                            end
                            else
                            begin
                                fail = 1'b1;
                            end
                        end
                        else if (goal_hit)
                        begin
                            succ = 1'b1;
                        end
                        else
                        begin
                            kind_next  = jprs_pkg::K_SIDE;
                            j_next     = 1'b0;
                            side_next  = 1'b0;
                            state_next = jprs_pkg::ST_READ;
                        end
                    end
                    jprs_pkg::K_SIDE:
                    begin
                        if (probe.on && probe.blk)
                        begin
                            kind_next  = jprs_pkg::K_FWD;
                            state_next = jprs_pkg::ST_READ;
                        end
                        else
                        begin
                            nxt_side = 1'b1;
                        end
                    end
                    jprs_pkg::K_FWD:
                    begin
                        if (probe.on && !probe.blk)
                        begin
                            succ = 1'b1;
                        end
                        else
                        begin
                            nxt_side = 1'b1;
                        end
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase

                if (nxt_side)
                begin
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        kind_next  = jprs_pkg::K_SIDE;
                        state_next = jprs_pkg::ST_READ;
                    end
                    else if (!mode_reg && !j_reg)
                    begin
                        j_next     = 1'b1;
                        side_next  = 1'b0;
                        kind_next  = jprs_pkg::K_SIDE;
                        state_next = jprs_pkg::ST_READ;
                    end
                    else if (mode_reg)
                    begin
                        state_next = jprs_pkg::ST_STEP;
                    end
                    else
                    begin
                        mode_next  = 1'b1;
                        rdir_next  = dir_reg - 3'd1;
                        sub_next   = 1'b0;
                        rx_next    = dgx_reg;
                        ry_next    = dgy_reg;
                        state_next = jprs_pkg::ST_STEP;
                    end
                end

                if (sub_fail)
                begin
                    if (!sub_reg)
                    begin
                        sub_next  = 1'b1;
                        rdir_next = dir_reg + 3'd1;
                        rx_next   = dgx_reg;
                        ry_next   = dgy_reg;
                    end
                    else
                    begin
                        mode_next = 1'b0;
                    end
                    state_next = jprs_pkg::ST_STEP;
                end

                if (fail)
                begin
                    found_next = 1'b0;
                    resx_next  = '0;
                    resy_next  = '0;
                    state_next = jprs_pkg::ST_DONE;
                end

                if (succ)
                begin
                    found_next = 1'b1;
                    resx_next  = dir_reg[0] ? $unsigned(dgx_reg) : $unsigned(rx_reg);
                    resy_next  = dir_reg[0] ? $unsigned(dgy_reg) : $unsigned(ry_reg);
                    state_next = jprs_pkg::ST_DONE;
                end
            end
            jprs_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = found_reg;
                    m_data_next  = found_reg ? {point_id, resy_reg[7:0], resx_reg[7:0]}
                                             : 32'd0;
                    state_next   = jprs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jprs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jprs_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            grid_size_reg <= 9'(jprs_pkg::MAX_GRID);
            goal_x_reg    <= 8'd0;
            goal_y_reg    <= 8'd0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jprs_pkg::CFG_GRID_SIZE: grid_size_reg <= cfg_data;
                    jprs_pkg::CFG_GOAL_X:    goal_x_reg    <= cfg_data[7:0];
                    jprs_pkg::CFG_GOAL_Y:    goal_y_reg    <= cfg_data[7:0];
                    default:                 grid_size_reg <= grid_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        mode_reg   <= mode_next;
        j_reg      <= j_next;
        side_reg   <= side_next;
        sub_reg    <= sub_next;
        dir_reg    <= dir_next;
        rdir_reg   <= rdir_next;
        dgx_reg    <= dgx_next;
        dgy_reg    <= dgy_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        found_reg  <= found_next;
        resx_reg   <= resx_next;
        resy_reg   <= resy_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == jprs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ design/jprs_checker.sv @@
// Port-level checker for the jump point ray scan block and its bind.
`include "jump_point_ray_scan_top_assert.svh"

module jprs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [31:0] m_tdata
);

    // A scan occupies the sequencer, so the input side must close at once.
    `JPRS_ASSERT_NEXT(a_scan_busy, s_tvalid && s_tready && s_tuser, !s_tready, "scan not busy")

    // A miss carries an all-zero point.
    `JPRS_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "miss not zero")

    // A stalled result word stays offered.
    `JPRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

bind jump_point_ray_scan_top jprs_checker u_jprs_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for the jump point ray scan block: map loads, scans and config phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS = 2048;
    localparam int CYCLE_LIMIT = 3000000;
    // Rows below the wall row are loaded with random obstacles; the wall row is fully
    // blocked, so scans that start left of it never reach rows that were not loaded.
    localparam int WALL_ROW = 47;

    typedef struct {
        logic       cmd;
        logic [7:0] row;
        logic [2:0] widx;
        logic [31:0] data;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [2:0] dir;
    } req_t;

    typedef struct {
        logic        hit;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [15:0] pid;
    } jump_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    req_t  pending_q[$];
    jump_t jump_q[$];
    req_t  cur_req;
    logic [31:0] map_mem [MAP_WORDS];
    logic [8:0]  grid_reg;
    logic [7:0]  goal_x_reg;
    logic [7:0]  goal_y_reg;
    int    errors;
    int    cycles;
    int    gap_left;
    int    stall_left;
    bit    quiet;
    bit    long_hold_req;
    bit    in_acc;

    jump_point_ray_scan_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int grid_n();
        return (grid_reg > 9'd256) ? 256 : int'(grid_reg);
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < grid_n() && y < grid_n();
    endfunction

    function automatic bit cell_blocked(int x, int y);
        logic [31:0] w;
        w = map_mem[(x * 8 + y / 32) % MAP_WORDS];
        return w[31 - (y % 32)];
    endfunction

    function automatic int step_x(int d);
        return int'(jprs_pkg::dir_dx(3'(d)));
    endfunction

    function automatic int step_y(int d);
        return int'(jprs_pkg::dir_dy(3'(d)));
    endfunction

    function automatic bit forced_side(int x, int y, int d);
        int dx, dy, px, py, sx, sy;
        dx = step_x(d);
        dy = step_y(d);
        for (int side = 0; side < 2; side++)
        begin
            px = side ? dy : -dy;
            py = side ? -dx : dx;
            sx = x + px;
            sy = y + py;
            if (on_grid(sx, sy) && cell_blocked(sx, sy) && on_grid(sx + dx, sy + dy)
                && !cell_blocked(sx + dx, sy + dy))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit at_goal(int x, int y);
        return x == int'(goal_x_reg) && y == int'(goal_y_reg);
    endfunction

    function automatic bit ray_walk(int x, int y, int d, output int ox, output int oy);
        ox = 0;
        oy = 0;
        forever
        begin
            x += step_x(d);
            y += step_y(d);
            if (!on_grid(x, y) || cell_blocked(x, y))
                return 1'b0;
            if (at_goal(x, y) || forced_side(x, y, d))
            begin
                ox = x;
                oy = y;
                return 1'b1;
            end
        end
    endfunction

    function automatic jump_t predict_jump(int x, int y, int d);
        jump_t r;
        int ox, oy, rx, ry;
        bit hit;
        r = '{1'b0, 8'd0, 8'd0, 16'd0};
        ox = 0;
        oy = 0;
        if ((d & 1) == 0)
            hit = ray_walk(x, y, d, ox, oy);
        else
        begin
            hit = 1'b0;
            forever
            begin
                x += step_x(d);
                y += step_y(d);
                if (!on_grid(x, y) || cell_blocked(x, y))
                    break;
                if (at_goal(x, y) || forced_side(x, y, (d - 1) & 7)
                    || forced_side(x, y, (d + 1) & 7)
                    || ray_walk(x, y, (d - 1) & 7, rx, ry)
                    || ray_walk(x, y, (d + 1) & 7, rx, ry))
                begin
                    hit = 1'b1;
                    ox = x;
                    oy = y;
                    break;
                end
            end
        end
        if (hit)
        begin
            r.hit = 1'b1;
            r.px = 8'(ox);
            r.py = 8'(oy);
            r.pid = 16'(ox * int'(grid_reg) + oy);
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        in_acc = s_tvalid && s_tready;
        if (in_acc)
        begin
            if (cur_req.cmd == jprs_pkg::CMD_WRITE)
                map_mem[{cur_req.row, cur_req.widx}] = cur_req.data;
            else
                jump_q = {jump_q, predict_jump(cur_req.sx, cur_req.sy, cur_req.dir)};
        end
        if (m_tvalid && m_tready)
        begin
            if (jump_q.size() == 0)
                report("unexpected word", m_tdata, 32'd0);
            else
            begin
                jump_t e;
                e = jump_q.pop_front();
                if (m_tuser !== e.hit) report("found", m_tuser, e.hit);
                if (m_tdata[7:0] !== e.px) report("point_x", m_tdata[7:0], e.px);
                if (m_tdata[15:8] !== e.py) report("point_y", m_tdata[15:8], e.py);
                if (m_tdata[31:16] !== e.pid) report("point_id", m_tdata[31:16], e.pid);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_acc))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_req.cmd;
                s_tdata <= {2'b00, cur_req.dir, cur_req.sy, cur_req.sx, cur_req.data,
                            cur_req.widx, cur_req.row};
            end
            else
                s_tvalid <= 1'b0;
        end
        in_acc = 1'b0;
    end

    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            stall_left = 400;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == jprs_pkg::CFG_GRID_SIZE) grid_reg = val;
        else if (idx == jprs_pkg::CFG_GOAL_X) goal_x_reg = val[7:0];
        else goal_y_reg = val[7:0];
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && !s_tvalid && jump_q.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic add_write(int row, int widx, logic [31:0] data);
        req_t r;
        r = '{jprs_pkg::CMD_WRITE, 8'(row), 3'(widx), data, 8'd0, 8'd0, 3'd0};
        pending_q = {pending_q, r};
    endtask

    task automatic add_scan(int x, int y, int d);
        req_t r;
        r = '{jprs_pkg::CMD_SCAN, 8'd0, 3'd0, 32'd0, 8'(x), 8'(y), 3'(d)};
        r.row = 8'($urandom);
        r.widx = 3'($urandom);
        r.data = $urandom;
        pending_q = {pending_q, r};
    endtask

    task automatic random_phase(int scans);
        int n;
        int xmax;
        n = grid_n() > 0 ? grid_n() : 1;
        xmax = (n < WALL_ROW) ? n - 1 : WALL_ROW - 1;
        for (int i = 0; i < scans; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_write($urandom_range(0, WALL_ROW - 1), $urandom_range(0, 7),
                          $urandom & $urandom);
            if ($urandom_range(0, 7) == 0 && n < WALL_ROW)
                add_scan($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 7));
            else
                add_scan($urandom_range(0, xmax), $urandom_range(0, n - 1),
                         $urandom_range(0, 7));
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = jprs_pkg::CFG_GRID_SIZE;
        cfg_data = '0;
        grid_reg = 9'd256;
        goal_x_reg = 8'd0;
        goal_y_reg = 8'd0;
        errors = 0;
        cycles = 0;
        gap_left = 0;
        stall_left = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        in_acc = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < (WALL_ROW + 1) * 8; i++)
            add_write(i / 8, i % 8, (i / 8 == WALL_ROW) ? 32'hFFFF_FFFF : $urandom & $urandom);
        wait_idle();

        write_reg(jprs_pkg::CFG_GOAL_X, 9'd20);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd100);
        add_write(20, 3, 32'h0000_0000);
        add_write(21, 3, 32'hFFFF_FFFF);
        add_write(19, 3, 32'h0000_0000);
        add_scan(20, 96, 4);
        add_scan(20, 127, 0);
        for (int d = 0; d < 8; d++)
        begin
            add_scan(0, 0, d);
            add_scan(WALL_ROW - 1, 255, d);
        end
        add_scan(0, 255, 1);
        add_scan(WALL_ROW - 1, 0, 5);
        wait_idle();

        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd0);
        random_phase(20);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd1);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd0);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd0);
        random_phase(20);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd511);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd255);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd255);
        long_hold_req = 1'b1;
        random_phase(30);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd300);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd17);
        random_phase(20);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd16);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd3);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd4);
        random_phase(40);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd32);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd20);
        random_phase(40);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd7);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd10);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd10);
        random_phase(30);
        write_reg(jprs_pkg::CFG_GRID_SIZE, 9'd256);
        write_reg(jprs_pkg::CFG_GOAL_X, 9'd30);
        write_reg(jprs_pkg::CFG_GOAL_Y, 9'd64);
        random_phase(40);
        quiet = 1'b1;
        random_phase(40);

        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
